FILE: sv/delta_list_timer_queue_defines.svh
// assertion macros for the delta list timer queue
`ifndef DELTA_LIST_TIMER_QUEUE_DEFINES_SVH
`define DELTA_LIST_TIMER_QUEUE_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define DLTQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define DLTQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/dltq_pkg.sv
// package with shared types and constants of the delta list timer queue
`default_nettype none
package dltq_pkg;
  localparam int unsigned TimerCount = 16;
  localparam int unsigned MaxFires   = 32;
  localparam int unsigned IdW        = $clog2(TimerCount);
  localparam int unsigned PtrW       = IdW + 1;
  localparam int unsigned FireW      = $clog2(MaxFires + 1);
  localparam logic [PtrW-1:0] NilSlot = PtrW'(TimerCount);

  typedef enum logic [1:0] {
    FuncAdd    = 2'd0,
    FuncRemove = 2'd1,
    FuncTick   = 2'd2,
    FuncQuery  = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    StIdle,
    StAddWalk,
    StRemove,
    StTickHead,
    StTickFire,
    StInsWalk,
    StOut
  } state_e;

  typedef struct packed {
    logic        status;
    logic        fired;
    logic [3:0]  expired_id;
    logic [31:0] remaining_ms;
    logic        last;
  } result_t;
endpackage
`default_nettype wire

FILE: sv/delta_list_timer_queue.sv
// top level of the delta list timer queue
// Timer queue kept as a delta list of TimerCount slots, one command per
// s_axis transfer. tdata packs func, timer_id, interval_ms, periodic and
// elapsed_ms; m_axis carries one result per transfer, tlast on the final one.
// The block takes one command at a time: s_axis_tready is high only in idle,
// and it returns after the last result transfer of a command, once out_v_q
// has cleared and the sequencer has stepped from StOut back to idle.
// Add walks the list one entry a cycle through the shared subtractor.
// Remove passes through StRemove; query and rejected commands answer at once.
// Tick checks the head until the list is empty, the head is not yet due or
// MaxFires timers have fired; each fired timer costs one output transfer
// plus a reinsert walk when periodic, then the final result.
// Each result waits in an output register until m_axis_tready; the sequencer
// stalls while it waits, so nothing is lost under back pressure.
// Reset clears the active bits and empties the list; slot storage is left
// undefined and only read after an add has written it.
`default_nettype none
`include "delta_list_timer_queue_defines.svh"
module delta_list_timer_queue (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // func[1:0], timer_id[5:2], interval_ms[37:6], periodic[38], elapsed_ms[70:39]
  input  wire logic [71:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status[0], fired[1], expired_id[5:2], remaining_ms[37:6]
  output logic [39:0]      m_axis_tdata,
  output logic             m_axis_tlast
);
  localparam int unsigned PW = dltq_pkg::PtrW;
  localparam int unsigned IW = dltq_pkg::IdW;

  // slot storage
  logic [31:0]   delta_q  [dltq_pkg::TimerCount];
  logic [31:0]   reload_q [dltq_pkg::TimerCount];
  logic          rflag_q  [dltq_pkg::TimerCount];
  logic [PW-1:0] next_q   [dltq_pkg::TimerCount];
  logic [PW-1:0] prev_q   [dltq_pkg::TimerCount];
  logic [dltq_pkg::TimerCount-1:0] active_q;
  logic [PW-1:0] head_q, tail_q;

  dltq_pkg::state_e state_q, state_d;
  logic [PW-1:0]  cur_q;        // walk cursor
  logic [IW-1:0]  slot_q;       // slot being inserted or removed
  logic [31:0]    acc_q;        // remaining insert delay or elapsed time
  logic [dltq_pkg::FireW-1:0] fires_q;
  dltq_pkg::result_t res_q;
  logic           out_v_q;

  // input fields
  logic [1:0]  in_func;
  logic [IW-1:0] in_id;
  logic [31:0] in_interval, in_elapsed;
  logic        in_per;
  assign in_func     = s_axis_tdata[1:0];
  assign in_id       = s_axis_tdata[2 +: IW];
  assign in_interval = s_axis_tdata[37:6];
  assign in_per      = s_axis_tdata[38];
  assign in_elapsed  = s_axis_tdata[70:39];

  logic in_xfer, out_xfer;
  assign s_axis_tready = (state_q == dltq_pkg::StIdle);
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  // immediate status and query value of an incoming command
  logic        in_bad;
  logic [31:0] in_rem;
  always_comb begin
    in_bad = 1'b0;
    in_rem = '0;
    case (dltq_pkg::func_e'(in_func))
      dltq_pkg::FuncAdd:    in_bad = active_q[in_id];
      dltq_pkg::FuncRemove: in_bad = !active_q[in_id];
      dltq_pkg::FuncQuery: begin
        if (head_q != dltq_pkg::NilSlot) in_rem = delta_q[head_q[IW-1:0]];
      end
      default: ;
    endcase
  end

  // shared subtract/compare unit: acc against the cursor entry delta
  logic [IW-1:0] cur_idx;
  logic [31:0]   cur_delta, sub_diff, sub_a, sub_b;
  logic          sub_gt, sub_eq;
  assign cur_idx   = (state_q == dltq_pkg::StTickHead) ? head_q[IW-1:0] : cur_q[IW-1:0];
  assign cur_delta = delta_q[cur_idx];
  always_comb begin
    sub_a = acc_q;
    sub_b = cur_delta;
    if (state_q == dltq_pkg::StTickHead && cur_delta > acc_q) begin
      sub_a = cur_delta;
      sub_b = acc_q;
    end
  end
  dltq_sub u_sub (
    .a_i(sub_a), .b_i(sub_b), .diff_o(sub_diff), .gt_o(sub_gt), .eq_o(sub_eq)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dltq_pkg::StIdle: begin
        if (in_xfer) begin
          case (dltq_pkg::func_e'(in_func))
            dltq_pkg::FuncAdd:
              state_d = active_q[in_id] ? dltq_pkg::StOut : dltq_pkg::StAddWalk;
            dltq_pkg::FuncRemove:
              state_d = active_q[in_id] ? dltq_pkg::StRemove : dltq_pkg::StOut;
            dltq_pkg::FuncTick:  state_d = dltq_pkg::StTickHead;
            dltq_pkg::FuncQuery: state_d = dltq_pkg::StOut;
            default:             state_d = dltq_pkg::StOut;
          endcase
        end
      end
      dltq_pkg::StAddWalk, dltq_pkg::StInsWalk: begin
        if (cur_q == dltq_pkg::NilSlot || !sub_gt)
          state_d = (state_q == dltq_pkg::StInsWalk) ? dltq_pkg::StTickHead
                                                     : dltq_pkg::StOut;
      end
      dltq_pkg::StRemove: state_d = dltq_pkg::StOut;
      dltq_pkg::StTickHead: begin
        if (head_q == dltq_pkg::NilSlot || fires_q == dltq_pkg::FireW'(dltq_pkg::MaxFires)
            || cur_delta > acc_q)
          state_d = dltq_pkg::StOut;
        else
          state_d = dltq_pkg::StTickFire;
      end
      dltq_pkg::StTickFire: begin
        if (!out_v_q)
          state_d = rflag_q[slot_q] ? dltq_pkg::StInsWalk : dltq_pkg::StTickHead;
      end
      dltq_pkg::StOut: if (!out_v_q) state_d = dltq_pkg::StIdle;
      default: state_d = dltq_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= dltq_pkg::StIdle;
    else         state_q <= state_d;
  end

  // linked-list datapath and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      head_q   <= dltq_pkg::NilSlot;
      tail_q   <= dltq_pkg::NilSlot;
      out_v_q  <= 1'b0;
      fires_q  <= '0;
    end else begin
      if (out_xfer) out_v_q <= 1'b0;
      case (state_q)
        dltq_pkg::StIdle: begin
          if (in_xfer) begin
            slot_q  <= in_id;
            cur_q   <= head_q;
            fires_q <= '0;
            res_q   <= '{status: in_bad, fired: 1'b0, expired_id: '0,
                         remaining_ms: in_rem, last: 1'b1};
            // rejected commands and queries answer at once
            out_v_q <= (state_d == dltq_pkg::StOut);
            case (dltq_pkg::func_e'(in_func))
              dltq_pkg::FuncAdd: begin
                acc_q <= in_interval;
                if (!active_q[in_id]) begin
                  reload_q[in_id] <= in_interval;
                  rflag_q[in_id]  <= in_per;
                  active_q[in_id] <= 1'b1;
                end
              end
              dltq_pkg::FuncTick: acc_q <= in_elapsed;
              default: ;
            endcase
          end
        end
        dltq_pkg::StAddWalk, dltq_pkg::StInsWalk: begin
          if (cur_q == dltq_pkg::NilSlot) begin
            // append at the tail
            delta_q[slot_q] <= acc_q;
            prev_q[slot_q]  <= tail_q;
            next_q[slot_q]  <= dltq_pkg::NilSlot;
            if (tail_q == dltq_pkg::NilSlot) head_q <= {1'b0, slot_q};
            else next_q[tail_q[IW-1:0]] <= {1'b0, slot_q};
            tail_q <= {1'b0, slot_q};
          end else if (sub_gt) begin
            acc_q <= sub_diff;
            cur_q <= next_q[cur_idx];
          end else if (sub_eq) begin
            // equal deadline goes after the existing entry
            delta_q[slot_q] <= '0;
            prev_q[slot_q]  <= cur_q;
            next_q[slot_q]  <= next_q[cur_idx];
            next_q[cur_idx] <= {1'b0, slot_q};
            if (next_q[cur_idx] == dltq_pkg::NilSlot) tail_q <= {1'b0, slot_q};
            else prev_q[next_q[cur_idx][IW-1:0]] <= {1'b0, slot_q};
          end else begin
            delta_q[cur_idx] <= cur_delta - acc_q;
            delta_q[slot_q]  <= acc_q;
            prev_q[slot_q]   <= prev_q[cur_idx];
            next_q[slot_q]   <= cur_q;
            prev_q[cur_idx]  <= {1'b0, slot_q};
            if (prev_q[cur_idx] == dltq_pkg::NilSlot) head_q <= {1'b0, slot_q};
            else next_q[prev_q[cur_idx][IW-1:0]] <= {1'b0, slot_q};
          end
          if ((cur_q == dltq_pkg::NilSlot || !sub_gt) && state_q == dltq_pkg::StInsWalk)
            begin
              acc_q <= res_q.remaining_ms;
              cur_q <= head_q;
            end
          if ((cur_q == dltq_pkg::NilSlot || !sub_gt) && state_q == dltq_pkg::StAddWalk)
            out_v_q <= 1'b1;
        end
        dltq_pkg::StRemove: begin
          // unlink and hand the delta to the successor
          if (prev_q[slot_q] == dltq_pkg::NilSlot) head_q <= next_q[slot_q];
          else next_q[prev_q[slot_q][IW-1:0]] <= next_q[slot_q];
          if (next_q[slot_q] == dltq_pkg::NilSlot) tail_q <= prev_q[slot_q];
          else begin
            prev_q[next_q[slot_q][IW-1:0]] <= prev_q[slot_q];
            delta_q[next_q[slot_q][IW-1:0]] <=
              delta_q[next_q[slot_q][IW-1:0]] + delta_q[slot_q];
          end
          active_q[slot_q] <= 1'b0;
          out_v_q <= 1'b1;
        end
        dltq_pkg::StTickHead: begin
          cur_q <= head_q;
          if (head_q == dltq_pkg::NilSlot
              || fires_q == dltq_pkg::FireW'(dltq_pkg::MaxFires)) begin
            res_q <= '{status: 1'b0, fired: 1'b0, expired_id: '0,
                       remaining_ms: acc_q, last: 1'b1};
            out_v_q <= 1'b1;
          end else if (cur_delta > acc_q) begin
            delta_q[cur_idx] <= sub_diff;
            res_q <= '{status: 1'b0, fired: 1'b0, expired_id: '0,
                       remaining_ms: '0, last: 1'b1};
            out_v_q <= 1'b1;
          end else begin
            // head fires: unlink it and report it
            acc_q  <= sub_diff;
            slot_q <= cur_idx;
            head_q <= next_q[cur_idx];
            if (next_q[cur_idx] == dltq_pkg::NilSlot) tail_q <= dltq_pkg::NilSlot;
            else prev_q[next_q[cur_idx][IW-1:0]] <= dltq_pkg::NilSlot;
            fires_q <= fires_q + 1'b1;
            res_q <= '{status: 1'b0, fired: 1'b1, expired_id: cur_idx,
                       remaining_ms: '0, last: 1'b0};
            out_v_q <= 1'b1;
          end
        end
        dltq_pkg::StTickFire: begin
          if (!out_v_q) begin
            if (rflag_q[slot_q]) begin
              // park leftover time in the result register during the walk
              res_q.remaining_ms <= acc_q;
              acc_q <= reload_q[slot_q];
              cur_q <= head_q;
            end else begin
              active_q[slot_q] <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tlast  = res_q.last;
  assign m_axis_tdata  = {2'b00, res_q.remaining_ms, res_q.expired_id,
                          res_q.fired, res_q.status};

  logic unused_tail;
  assign unused_tail = s_axis_tdata[71];

  // checks
  `DLTQ_ASSERT_IMP(a_ready_idle, s_axis_tready, !m_axis_tvalid)
  `DLTQ_ASSERT_IMP(a_fired_not_last, m_axis_tvalid && m_axis_tdata[1], !m_axis_tlast)
  `DLTQ_ASSERT_NEXT(a_accept_busy, in_xfer, !s_axis_tready)
endmodule
`default_nettype wire

FILE: sv/dltq_sub.sv
// shared subtract and compare unit used by every list walk step
`default_nettype none
module dltq_sub (
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic [31:0]      diff_o,
  output logic             gt_o,
  output logic             eq_o
);
  logic [32:0] wide;
  // one wide subtract gives both the difference and the ordering
  always_comb begin
    wide   = {1'b0, a_i} - {1'b0, b_i};
    diff_o = wide[31:0];
    eq_o   = (a_i == b_i);
    gt_o   = !wide[32] && !eq_o;
  end
endmodule
`default_nettype wire
